// File: design/tlbpt_pkg.sv
// Shared types and constants for the TLB / page-table translator.
// Used by tlbpt_ctrl, tlbpt_datapath and tlb_page_table_translator_core.
package tlbpt_pkg;

  localparam int ADDR_W  = 16;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_LOOK,
    ST_MAP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;       // capture the incoming logical address
    logic mod_step;  // one conditional-subtract step of the page reduction
    logic clr_step;  // clear one page-table entry
    logic map_rd;    // read page table at the current page
    logic res_hit;   // commit a TLB hit result
    logic res_miss;  // commit a TLB miss result (page table data valid)
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tlb_hit;
    logic clr_last;
  } sts_t;

endpackage

// File: design/tlb_page_table_translator_core.sv
// TLB / page-table translator top level. TLB hit: the result is committed from
// ST_LOOK, one address per cycle sustained while the output is not stalled;
// TLB miss: ST_MAP follows ST_LOOK for the synchronous page-table read.
// Addresses wider than the page table first go through the ST_MOD reduction steps.
// Reset (rst_n low, synchronous) clears TLB, counters and allocator, then
// a clearing pass zeroes every page-table entry before input is taken.
module tlb_page_table_translator_core #(
  parameter int TLB_DEPTH   = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] logical_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] physical_address, [31:16] hit_total,
                                  // [47:32] fault_total
  output logic [1:0]  out_tuser   // [0] tlb_hit, [1] page_fault
);

  localparam int RAW_BITS  = tlbpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int PAGE_BITS = $clog2(PAGE_COUNT);
  localparam int MOD_STEPS = (PAGE_COUNT < (1 << RAW_BITS)) ? RAW_BITS - PAGE_BITS + 1 : 0;

  tlbpt_pkg::cmd_t cmd;
  tlbpt_pkg::sts_t sts;

  tlbpt_ctrl #(
    .MOD_STEPS (MOD_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tlbpt_datapath #(
    .TLB_DEPTH   (TLB_DEPTH),
    .PAGE_COUNT  (PAGE_COUNT),
    .OFFSET_BITS (OFFSET_BITS),
    .MOD_STEPS   (MOD_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_addr   (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// File: design/tlbpt_ctrl.sv
// Controller FSM for the TLB / page-table translator.
// Depends on tlbpt_pkg (state_t, cmd_t, sts_t).
module tlbpt_ctrl #(
  parameter int MOD_STEPS = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  tlbpt_pkg::sts_t sts,
  output tlbpt_pkg::cmd_t cmd
);

  localparam int CNT_W = (MOD_STEPS > 0) ? $clog2(MOD_STEPS + 1) : 1;
  localparam int LAST_STEP = (MOD_STEPS > 0) ? MOD_STEPS - 1 : 0;

  tlbpt_pkg::state_t state_r, state_nxt;
  tlbpt_pkg::state_t after_cap;
  logic [CNT_W-1:0]  mod_cnt_r, mod_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              can_load;

  assign out_tvalid = out_valid_r;
  assign can_load   = !out_valid_r || out_tready;
  assign after_cap  = (MOD_STEPS > 0) ? tlbpt_pkg::ST_MOD : tlbpt_pkg::ST_LOOK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlbpt_pkg::ST_CLEAR;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mod_cnt_nxt   = mod_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      tlbpt_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = tlbpt_pkg::ST_IDLE;
        end
      end
      tlbpt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap     = 1'b1;
          mod_cnt_nxt = '0;
          state_nxt   = after_cap;
        end
      end
      tlbpt_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        mod_cnt_nxt  = mod_cnt_r + 1'b1;
        if (mod_cnt_r == CNT_W'(LAST_STEP)) begin
          state_nxt = tlbpt_pkg::ST_LOOK;
        end
      end
      tlbpt_pkg::ST_LOOK: begin
        cmd.map_rd = 1'b1;
        if (!sts.tlb_hit) begin
          state_nxt = tlbpt_pkg::ST_MAP;
        end else if (can_load) begin
          cmd.res_hit   = 1'b1;
          out_valid_nxt = 1'b1;
          in_tready     = 1'b1;
          if (in_tvalid) begin
            cmd.cap     = 1'b1;
            mod_cnt_nxt = '0;
            state_nxt   = after_cap;
          end else begin
            state_nxt = tlbpt_pkg::ST_IDLE;
          end
        end
      end
      tlbpt_pkg::ST_MAP: begin
        if (can_load) begin
          cmd.res_miss  = 1'b1;
          out_valid_nxt = 1'b1;
          in_tready     = 1'b1;
          if (in_tvalid) begin
            cmd.cap     = 1'b1;
            mod_cnt_nxt = '0;
            state_nxt   = after_cap;
          end else begin
            state_nxt = tlbpt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tlbpt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/tlbpt_datapath.sv
// Datapath: TLB entries and compare, page-table memory, frame allocator,
// counters and the result register. Depends on tlbpt_pkg.
module tlbpt_datapath #(
  parameter int TLB_DEPTH   = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int OFFSET_BITS = 8,
  parameter int MOD_STEPS   = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlbpt_pkg::cmd_t              cmd,
  output tlbpt_pkg::sts_t              sts,
  input  logic [tlbpt_pkg::ADDR_W-1:0] in_addr,
  output logic [47:0]                  out_tdata,
  output logic [1:0]                   out_tuser
);

  localparam int RAW_BITS  = tlbpt_pkg::ADDR_W - OFFSET_BITS;
  localparam int PAGE_BITS = $clog2(PAGE_COUNT);
  localparam int NF_W      = $clog2(PAGE_COUNT + 1);
  localparam int TIDX_W    = $clog2(TLB_DEPTH);
  localparam int DIV_W     = RAW_BITS + 1;
  localparam int DIV_SH    = (MOD_STEPS > 0) ? MOD_STEPS - 1 : 0;
  localparam int MEM_W     = PAGE_BITS + 1;

  // input capture and page reduction
  logic [RAW_BITS-1:0]    page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [DIV_W-1:0]       div_r;
  logic [PAGE_BITS-1:0]   page_idx;

  // TLB
  logic                 tlb_valid_r [TLB_DEPTH];
  logic [PAGE_BITS-1:0] tlb_page_r  [TLB_DEPTH];
  logic [PAGE_BITS-1:0] tlb_frame_r [TLB_DEPTH];
  logic [TIDX_W-1:0]    fill_r;
  logic                 hit;
  logic [PAGE_BITS-1:0] hit_frame;

  // page table, valid bit on top
  logic [MEM_W-1:0]     map_mem [PAGE_COUNT];
  logic [MEM_W-1:0]     map_q_r;
  logic [PAGE_BITS-1:0] clr_addr_r;
  logic                 mem_we;
  logic [PAGE_BITS-1:0] mem_wa;
  logic [MEM_W-1:0]     mem_wd;

  logic [NF_W-1:0]      next_free_r;
  logic                 fault;
  logic [PAGE_BITS-1:0] miss_frame;

  logic [tlbpt_pkg::COUNT_W-1:0] hit_cnt_r, fault_cnt_r;
  logic [tlbpt_pkg::ADDR_W-1:0]  phys_r;
  logic                          hit_flag_r, fault_flag_r;
  logic [tlbpt_pkg::COUNT_W-1:0] hit_tot_r, fault_tot_r;
  logic [tlbpt_pkg::COUNT_W-1:0] hit_inc, fault_inc;

  assign page_idx = PAGE_BITS'(page_r);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      page_r   <= in_addr[tlbpt_pkg::ADDR_W-1:OFFSET_BITS];
      offset_r <= in_addr[OFFSET_BITS-1:0];
      div_r    <= DIV_W'(PAGE_COUNT << DIV_SH);
    end else if (cmd.mod_step) begin
      if ({1'b0, page_r} >= div_r) begin
        page_r <= page_r - RAW_BITS'(div_r);
      end
      div_r <= div_r >> 1;
    end
  end

  // lowest-numbered valid match wins
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (tlb_valid_r[i] && tlb_page_r[i] == page_idx) begin
        hit       = 1'b1;
        hit_frame = tlb_frame_r[i];
      end
    end
  end

  assign fault      = !map_q_r[PAGE_BITS];
  assign miss_frame = fault ? PAGE_BITS'(next_free_r) : map_q_r[PAGE_BITS-1:0];

  assign sts.tlb_hit  = hit;
  assign sts.clr_last = (clr_addr_r == PAGE_BITS'(PAGE_COUNT - 1));

  assign mem_we = cmd.clr_step || (cmd.res_miss && fault);
  assign mem_wa = cmd.clr_step ? clr_addr_r : page_idx;
  assign mem_wd = cmd.clr_step ? '0 : {1'b1, miss_frame};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    if (cmd.map_rd) begin
      map_q_r <= map_mem[page_idx];
    end
  end

  assign hit_inc   = (hit_cnt_r == tlbpt_pkg::COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
  assign fault_inc = (fault_cnt_r == tlbpt_pkg::COUNT_MAX) ? fault_cnt_r : fault_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
        tlb_valid_r[i] <= 1'b0;
      end
      fill_r      <= '0;
      next_free_r <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
      clr_addr_r  <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.res_hit) begin
        hit_cnt_r <= hit_inc;
      end
      if (cmd.res_miss) begin
        tlb_valid_r[fill_r] <= 1'b1;
        fill_r <= (fill_r == TIDX_W'(TLB_DEPTH - 1)) ? '0 : fill_r + 1'b1;
        if (fault) begin
          fault_cnt_r <= fault_inc;
          if (next_free_r < NF_W'(PAGE_COUNT)) begin
            next_free_r <= next_free_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_miss) begin
      tlb_page_r[fill_r]  <= page_idx;
      tlb_frame_r[fill_r] <= miss_frame;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_hit) begin
      phys_r       <= tlbpt_pkg::ADDR_W'((32'(hit_frame) << OFFSET_BITS) | 32'(offset_r));
      hit_flag_r   <= 1'b1;
      fault_flag_r <= 1'b0;
      hit_tot_r    <= hit_inc;
      fault_tot_r  <= fault_cnt_r;
    end else if (cmd.res_miss) begin
      phys_r       <= tlbpt_pkg::ADDR_W'((32'(miss_frame) << OFFSET_BITS) | 32'(offset_r));
      hit_flag_r   <= 1'b0;
      fault_flag_r <= fault;
      hit_tot_r    <= hit_cnt_r;
      fault_tot_r  <= fault ? fault_inc : fault_cnt_r;
    end
  end

  assign out_tdata = {fault_tot_r, hit_tot_r, phys_r};
  assign out_tuser = {fault_flag_r, hit_flag_r};

endmodule
